>>> rtl/gauss_jordan_matrix_inverse_unit_defines.svh
// assertion macros for the matrix inverse unit
// no dependencies; included by the files that carry assertions
`ifndef GAUSS_JORDAN_MATRIX_INVERSE_UNIT_DEFINES_SVH
`define GAUSS_JORDAN_MATRIX_INVERSE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GJMI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gjmi assertion failed");

// next-cycle implication, checked out of reset
`define GJMI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gjmi assertion failed");

`endif

>>> rtl/gjmi_pkg.sv
// shared types, constants and arithmetic helpers of the matrix inverse unit
// no dependencies
`default_nettype none

package gjmi_pkg;

    // 1.0 in Q16.16
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    // quotient bits of the reciprocal divider
    localparam int DIV_STEPS = 33;
    localparam int DCW = 6;

    typedef enum logic [4:0] {
        S_LOAD,
        S_PRD,
        S_PCHK,
        S_DIV,
        S_RCP,
        S_XRD,
        S_XMUL,
        S_XRND,
        S_XWR,
        S_ICHK,
        S_FRD,
        S_FLD,
        S_ORD,
        S_OLD,
        S_OWAIT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_wr;
        logic diag;
        logic div_start;
        logic recip_ld;
        logic mul_en;
        logic elim;
        logic rnd_en;
        logic wr_en;
        logic f_ld;
        logic out_ld;
        logic out_last;
        logic out_sing;
    } t_cmd;

    // status from the datapath
    typedef struct packed {
        logic piv_zero;
        logic div_busy;
    } t_stat;

    // magnitude of a signed word, 2^31 for the most negative
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m;
    endfunction

    // apply sign to a magnitude and saturate to 32 bits
    function automatic logic signed [31:0] from_mag(input logic [47:0] mag, input logic neg);
        logic [47:0] m;
        m = (mag > 48'h8000_0000) ? 48'h8000_0000 : mag;
        if (neg) begin
            return 32'(-m);
        end
        if (m > 48'h7FFF_FFFF) begin
            m = 48'h7FFF_FFFF;
        end
        return 32'(m);
    endfunction

    // saturate a 33-bit signed difference to 32 bits
    function automatic logic signed [31:0] clamp33(input logic signed [32:0] v);
        if (v > 33'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -33'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

endpackage

`default_nettype wire

>>> rtl/gjmi_dp.sv
// datapath: matrix stores, reciprocal divider, multiply-round lanes, output register
// depends on gjmi_pkg
`default_nettype none

module gjmi_dp
    import gjmi_pkg::*;
#(
    parameter int IW = 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic [2*IW-1:0]      i_addr_a,
    input  wire logic [2*IW-1:0]      i_addr_b,
    input  wire logic signed [31:0]   i_element_value,
    output t_stat                     o_stat,
    output logic signed [31:0]        o_inverse_value,
    output logic                      o_last_element,
    output logic                      o_singular
);

    localparam int DEPTH = 1 << (2 * IW);

    logic signed [31:0] r_wmem [DEPTH];
    logic signed [31:0] r_imem [DEPTH];
    logic signed [31:0] r_wa, r_wb, r_ia, r_ib;

    logic signed [31:0] r_f, r_recip;
    logic [63:0]        r_prod_w, r_prod_i;
    logic               r_neg_w, r_neg_i;
    logic signed [31:0] r_q_w, r_q_i;

    logic [31:0]        r_dm;
    logic               r_dsgn;
    logic [31:0]        r_rem;
    logic [32:0]        r_quo;
    logic [DCW-1:0]     r_dcnt;

    logic signed [31:0] r_oval;
    logic               r_olast, r_osing;

    logic signed [31:0] op_a_w, op_b_w, op_a_i, op_b_i;
    logic signed [31:0] n_wres, n_ires;
    logic [32:0]        trial;
    logic [31:0]        piv_mag;
    logic [63:0]        rsum_w, rsum_i;

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_wmem[i_addr_a] <= i_element_value;
            r_imem[i_addr_a] <= i_cmd.diag ? Q_ONE : 32'sd0;
        end else if (i_cmd.wr_en) begin
            r_wmem[i_addr_a] <= n_wres;
            r_imem[i_addr_a] <= n_ires;
        end
        r_wa <= r_wmem[i_addr_a];
        r_wb <= r_wmem[i_addr_b];
        r_ia <= r_imem[i_addr_a];
        r_ib <= r_imem[i_addr_b];
    end

    // operand selection: scaling uses the reciprocal, elimination the row factor
    always_comb begin
        op_a_w  = i_cmd.elim ? r_f  : r_wa;
        op_b_w  = i_cmd.elim ? r_wb : r_recip;
        op_a_i  = i_cmd.elim ? r_f  : r_ia;
        op_b_i  = i_cmd.elim ? r_ib : r_recip;
        rsum_w  = r_prod_w + 64'h8000;
        rsum_i  = r_prod_i + 64'h8000;
        n_wres  = i_cmd.elim ? clamp33(33'(r_wa) - 33'(r_q_w)) : r_q_w;
        n_ires  = i_cmd.elim ? clamp33(33'(r_ia) - 33'(r_q_i)) : r_q_i;
        trial   = {r_rem, r_quo[32]};
        piv_mag = mag32(r_wa);
    end

    // multiply then round and saturate, one register each
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_w <= 64'(mag32(op_a_w)) * 64'(mag32(op_b_w));
            r_prod_i <= 64'(mag32(op_a_i)) * 64'(mag32(op_b_i));
            r_neg_w  <= op_a_w[31] ^ op_b_w[31];
            r_neg_i  <= op_a_i[31] ^ op_b_i[31];
        end
        if (i_cmd.rnd_en) begin
            r_q_w <= from_mag(rsum_w[63:16], r_neg_w);
            r_q_i <= from_mag(rsum_i[63:16], r_neg_i);
        end
        if (i_cmd.f_ld) begin
            r_f <= r_wa;
        end
        if (i_cmd.recip_ld) begin
            r_recip <= from_mag({15'd0, r_quo}, r_dsgn);
        end
    end

    // restoring divider for 2^32 / |pivot|, rounded, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DCW'(DIV_STEPS);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dm   <= piv_mag;
            r_dsgn <= r_wa[31];
            r_rem  <= '0;
            r_quo  <= {1'b1, 32'd0} + {2'b00, piv_mag[31:1]};
        end else if (r_dcnt != '0) begin
            if (trial >= {1'b0, r_dm}) begin
                r_rem <= 32'(trial - {1'b0, r_dm});
                r_quo <= {r_quo[31:0], 1'b1};
            end else begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[31:0], 1'b0};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_oval  <= i_cmd.out_sing ? 32'sd0 : r_ia;
            r_olast <= i_cmd.out_last;
            r_osing <= i_cmd.out_sing;
        end
    end

    assign o_stat.piv_zero = (r_wa == 32'sd0);
    assign o_stat.div_busy = (r_dcnt != '0);
    assign o_inverse_value = r_oval;
    assign o_last_element  = r_olast;
    assign o_singular      = r_osing;

endmodule

`default_nettype wire

>>> rtl/gjmi_ctrl.sv
// controller: load, pivot, scale, eliminate and emit sequencing
// depends on gjmi_pkg and the assertion macro header
`default_nettype none
`include "gauss_jordan_matrix_inverse_unit_defines.svh"

module gjmi_ctrl
    import gjmi_pkg::*;
#(
    parameter int IW = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IW-1:0]     i_nm1,
    input  wire logic [IW:0]       i_n,
    input  wire logic              i_cfg_wr,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    input  wire t_stat             i_stat,
    output t_cmd                   o_cmd,
    output logic [2*IW-1:0]        o_addr_a,
    output logic [2*IW-1:0]        o_addr_b
);

    t_state         r_state, n_state;
    logic [IW-1:0]  r_k, n_k;
    logic [IW:0]    r_i, n_i;
    logic [IW-1:0]  r_j, n_j;
    logic           r_phase, n_phase;
    logic           r_sing, n_sing;
    logic           w_row_end, w_col_end;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_phase <= 1'b0;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_phase <= n_phase;
            r_sing  <= n_sing;
        end
    end

    assign w_col_end = (r_j == i_nm1);
    assign w_row_end = (r_i[IW-1:0] == i_nm1);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_phase  = r_phase;
        n_sing   = r_sing;
        o_cmd    = '0;
        o_cmd.elim     = r_phase;
        o_cmd.diag     = (r_i[IW-1:0] == r_j);
        o_cmd.out_last = w_row_end && w_col_end;
        o_cmd.out_sing = r_sing;
        o_addr_a = {r_i[IW-1:0], r_j};
        o_addr_b = {r_k, r_j};
        unique case (r_state)
            S_LOAD: begin
                if (i_cfg_wr) begin
                    n_i = '0;
                    n_j = '0;
                end else if (i_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (w_col_end) begin
                        n_j = '0;
                        if (w_row_end) begin
                            n_i     = '0;
                            n_k     = '0;
                            n_sing  = 1'b0;
                            n_state = S_PRD;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_PRD: begin
                o_addr_a = {r_k, r_k};
                n_state  = S_PCHK;
            end
            S_PCHK: begin
                o_addr_a = {r_k, r_k};
                if (i_stat.piv_zero) begin
                    n_sing  = 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_ORD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_RCP;
                end
            end
            S_RCP: begin
                o_cmd.recip_ld = 1'b1;
                n_j     = '0;
                n_phase = 1'b0;
                n_state = S_XRD;
            end
            S_XRD: begin
                if (!r_phase) o_addr_a = {r_k, r_j};
                n_state = S_XMUL;
            end
            S_XMUL: begin
                if (!r_phase) o_addr_a = {r_k, r_j};
                o_cmd.mul_en = 1'b1;
                n_state = S_XRND;
            end
            S_XRND: begin
                if (!r_phase) o_addr_a = {r_k, r_j};
                o_cmd.rnd_en = 1'b1;
                n_state = S_XWR;
            end
            S_XWR: begin
                if (!r_phase) o_addr_a = {r_k, r_j};
                o_cmd.wr_en = 1'b1;
                if (w_col_end) begin
                    n_j     = '0;
                    n_i     = r_phase ? r_i + 1'b1 : '0;
                    n_state = S_ICHK;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_XRD;
                end
            end
            S_ICHK: begin
                if (r_i == i_n) begin
                    if (r_k == i_nm1) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_ORD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_PRD;
                    end
                end else if (r_i == {1'b0, r_k}) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                o_addr_a = {r_i[IW-1:0], r_k};
                n_state  = S_FLD;
            end
            S_FLD: begin
                o_addr_a   = {r_i[IW-1:0], r_k};
                o_cmd.f_ld = 1'b1;
                n_phase    = 1'b1;
                n_j        = '0;
                n_state    = S_XRD;
            end
            S_ORD: begin
                n_state = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_ld = 1'b1;
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                if (!i_stall) begin
                    if (w_col_end) begin
                        n_j = '0;
                        if (w_row_end) begin
                            n_i     = '0;
                            n_state = S_LOAD;
                        end else begin
                            n_i     = r_i + 1'b1;
                            n_state = S_ORD;
                        end
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_stall = (r_state != S_LOAD);
    assign o_valid = (r_state == S_OWAIT);

    // no input is taken while a result is on offer
    `GJMI_ASSERT_IMP(a_out_blocks_in, i_clk, i_rst_n, o_valid, o_stall)
    // pivot index stays inside the matrix while working
    `GJMI_ASSERT_IMP(a_k_range, i_clk, i_rst_n, r_state != S_LOAD, r_k <= i_nm1)
    // transfer of the final result returns to loading
    `GJMI_ASSERT_NXT(a_last_to_load, i_clk, i_rst_n,
        o_valid && !i_stall && w_row_end && w_col_end, r_state == S_LOAD)

endmodule

`default_nettype wire

>>> rtl/gauss_jordan_matrix_inverse_unit.sv
// top level of the Gauss-Jordan matrix inverse unit: config register and wiring
// depends on gjmi_pkg, gjmi_ctrl and gjmi_dp
`default_nettype none

// Inverts an n by n signed Q16.16 matrix by Gauss-Jordan elimination without
// pivoting. Elements enter row-major, one per cycle; the matrix order is set
// through the APB register at addresses 0 to 3 (0 acts as 1, values above
// MAX_ORDER as MAX_ORDER); a write while loading restarts the load. After the last
// element the input stalls while the two element lanes, working and inverse
// matrix, work: each pivot is read and checked, then the one-bit-a-cycle
// reciprocal divider runs through its 33 quotient bits, the reciprocal is loaded
// and the rows are checked, and every element update of the scale and eliminate
// passes goes through read, multiply, round and write. The n*n results then
// leave one at a time, each held until the receiver takes it, the last one
// flagged; a zero pivot ends the run early and every result carries value 0
// with the singular flag set.
module gauss_jordan_matrix_inverse_unit
    import gjmi_pkg::*;
#(
    parameter int MAX_ORDER = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_element_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_inverse_value,
    output logic                    o_last_element,
    output logic                    o_singular
);

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    logic [3:0]       r_matrix_size;
    logic [3:0]       size_eff;
    logic             cfg_wr;
    logic [IW-1:0]    nm1;
    logic [IW:0]      n_ord;
    t_cmd             cmd;
    t_stat            stat;
    logic [2*IW-1:0]  addr_a, addr_b;

    // register transfer on the config port
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign pready = 1'b1;
    assign prdata = {28'd0, r_matrix_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= 4'd8;
        end else if (cfg_wr) begin
            r_matrix_size <= pwdata[3:0];
        end
    end

    // effective order, clamped into 1..MAX_ORDER
    always_comb begin
        if (r_matrix_size == 4'd0) begin
            size_eff = 4'd1;
        end else if (32'(r_matrix_size) > MAX_ORDER) begin
            size_eff = 4'(MAX_ORDER);
        end else begin
            size_eff = r_matrix_size;
        end
        nm1   = IW'(size_eff - 4'd1);
        n_ord = (IW + 1)'(size_eff);
    end

    gjmi_ctrl #(
        .IW (IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nm1    (nm1),
        .i_n      (n_ord),
        .i_cfg_wr (cfg_wr),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_addr_a (addr_a),
        .o_addr_b (addr_b)
    );

    gjmi_dp #(
        .IW (IW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr_a        (addr_a),
        .i_addr_b        (addr_b),
        .i_element_value (i_element_value),
        .o_stat          (stat),
        .o_inverse_value (o_inverse_value),
        .o_last_element  (o_last_element),
        .o_singular      (o_singular)
    );

endmodule

`default_nettype wire

>>> tb/sv/gjmi_checker.sv
// checker for the matrix inverse unit: watches both channels, predicts the inverse
// no package dependencies; driven by tb_gauss_jordan_matrix_inverse_unit
`timescale 1ns / 100ps
`default_nettype none

module gjmi_checker #(
    parameter int MAX_ORDER = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_size,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic signed [31:0] i_element_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic signed [31:0] i_inverse_value,
    input  wire logic               i_last_element,
    input  wire logic               i_singular,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results_seen,
    output int                      o_singular_seen
);

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               sing;
    } t_inv_elem;

    t_inv_elem inverse_fifo[$];
    logic [3:0] size_reg;
    longint work_m[64];
    longint inv_m[64];
    int load_idx;

    function automatic int order_of(input logic [3:0] s);
        if (s == 0) return 1;
        if (s > MAX_ORDER) return MAX_ORDER;
        return int'(s);
    endfunction

    function automatic longint sat_mag(input longint unsigned m, input bit neg);
        if (m > 64'h8000_0000) m = 64'h8000_0000;
        if (neg) return -longint'(m);
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        return longint'(m);
    endfunction

    function automatic longint clamp_word(input longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // q16.16 product, rounded half away from zero
    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned ma, mb;
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        return sat_mag((ma * mb + 64'h8000) >> 16, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_recip(input longint d);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : d;
        return sat_mag(((64'd1 << 32) + (m >> 1)) / m, d < 0);
    endfunction

    // invert the loaded matrix and queue the n*n expected inverse elements
    task automatic predict_inverse(input int n);
        bit ok;
        longint r, f;
        t_inv_elem e;
        ok = 1;
        for (int c = 0; c < n * n; c++) inv_m[c] = ((c / n) == (c % n)) ? 65536 : 0;
        for (int k = 0; k < n && ok; k++) begin
            if (work_m[k * n + k] == 0) begin
                ok = 0;
            end else begin
                r = fx_recip(work_m[k * n + k]);
                for (int j = 0; j < n; j++) begin
                    work_m[k * n + j] = fx_mul(work_m[k * n + j], r);
                    inv_m[k * n + j] = fx_mul(inv_m[k * n + j], r);
                end
                for (int i = 0; i < n; i++) begin
                    if (i != k) begin
                        f = work_m[i * n + k];
                        for (int j = 0; j < n; j++) begin
                            work_m[i * n + j] = clamp_word(work_m[i * n + j]
                                - fx_mul(f, work_m[k * n + j]));
                            inv_m[i * n + j] = clamp_word(inv_m[i * n + j]
                                - fx_mul(f, inv_m[k * n + j]));
                        end
                    end
                end
            end
        end
        for (int c = 0; c < n * n; c++) begin
            e.value = ok ? 32'(inv_m[c]) : '0;
            e.last = (c == n * n - 1);
            e.sing = !ok;
            inverse_fifo.push_back(e);
        end
    endtask

    assign o_pending = inverse_fifo.size();

    // track config, input transfers and output transfers
    always @(posedge i_clk) begin
        int n;
        int errs;
        t_inv_elem exp_e;
        errs = 0;
        if (!i_rst_n) begin
            size_reg <= 4'd8;
            load_idx = 0;
            o_fail_count <= 0;
            o_results_seen <= 0;
            o_singular_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                size_reg <= i_cfg_size;
                load_idx = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                n = order_of(size_reg);
                if (load_idx >= n * n) load_idx = 0;
                work_m[load_idx] = longint'(i_element_value);
                load_idx++;
                if (load_idx == n * n) begin
                    load_idx = 0;
                    predict_inverse(n);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (i_singular && i_last_element) o_singular_seen <= o_singular_seen + 1;
                if (inverse_fifo.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end else begin
                    exp_e = inverse_fifo.pop_front();
                    if (i_inverse_value !== exp_e.value) begin
                        $error("inverse_value expected %0d got %0d", exp_e.value,
                               i_inverse_value);
                        errs++;
                    end
                    if (i_last_element !== exp_e.last) begin
                        $error("last_element expected %0b got %0b", exp_e.last,
                               i_last_element);
                        errs++;
                    end
                    if (i_singular !== exp_e.sing) begin
                        $error("singular expected %0b got %0b", exp_e.sing, i_singular);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_gauss_jordan_matrix_inverse_unit.sv
// testbench top for the matrix inverse unit: stimulus, config writes and verdict
// depends on gauss_jordan_matrix_inverse_unit and gjmi_checker
`timescale 1ns / 100ps
`default_nettype none

module tb_gauss_jordan_matrix_inverse_unit;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [2:0] ADDR_MATRIX_SIZE = 3'd0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_element_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_inverse_value;
    logic o_last_element, o_singular;

    int fail_count, pending, results_seen, singular_seen;
    int cycle_count = 0;
    int matrices_sent = 0;
    bit hold_off = 0;
    bit random_stall = 0;
    logic [3:0] cur_size = 4'd8;

    always #1 i_clk = ~i_clk;

    gauss_jordan_matrix_inverse_unit DUT (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_valid, .o_stall, .i_element_value, .o_valid, .i_stall, .o_inverse_value,
        .o_last_element, .o_singular
    );

    gjmi_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_we(psel && penable && pwrite && pready && paddr == ADDR_MATRIX_SIZE),
        .i_cfg_size(pwdata[3:0]),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_element_value,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_inverse_value(o_inverse_value),
        .i_last_element(o_last_element), .i_singular(o_singular),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen),
        .o_singular_seen(singular_seen)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else if (random_stall) i_stall <= ($urandom_range(0, 3) == 0);
        else i_stall <= 1'b0;
    end

    task automatic write_size(input logic [3:0] s);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MATRIX_SIZE; pwdata <= 32'(s);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cur_size = s;
    endtask

    // one element transfer; valid stays high if another follows straight away
    task automatic send_element(input logic signed [31:0] v, input bit gap_after);
        i_valid <= 1'b1;
        i_element_value <= v;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (gap_after) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    function automatic int order_now();
        if (cur_size == 0) return 1;
        if (cur_size > 8) return 8;
        return int'(cur_size);
    endfunction

    // random element: mostly moderate values, sometimes zero or any word
    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'sh0;
            default: return $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
        endcase
    endfunction

    // one matrix, diagonally weighted when dominant is set, sent in random bursts when bursty is set
    task automatic send_matrix(input bit dominant, input bit bursty);
        int n, burst;
        logic signed [31:0] v;
        n = order_now();
        burst = $urandom_range(1, 6);
        for (int c = 0; c < n * n; c++) begin
            v = rand_elem();
            if (dominant && (c / n) == (c % n))
                v = $signed($urandom_range(32'h8_0000, 32'h10_0000)) *
                    ($urandom_range(0, 1) ? 1 : -1);
            burst--;
            send_element(v, bursty && burst == 0);
            if (burst == 0) burst = $urandom_range(1, 6);
        end
        i_valid <= 1'b0;
        matrices_sent++;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (900) @(negedge i_clk);
    endtask

    initial begin
        int sent;
        logic signed [31:0] extremes[6];
        extremes = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh1, -32'sh1, 32'sh0001_0000,
                     32'shFFFF_0000};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: order 1 with extreme words, zero pivot included
        write_size(4'd1);
        foreach (extremes[k]) send_element(extremes[k], 1'b0);
        send_element(32'sh0, 1'b1);
        i_valid <= 1'b0;
        drain();
        // order 2: identity, singular matrix, saturating entries
        write_size(4'd2);
        foreach (extremes[k]) send_element(k % 3 == 0 ? 32'sh0001_0000 : 32'sh0, 1'b0);
        send_element(32'sh0, 1'b0); send_element(32'sh0, 1'b0);
        send_element(32'sh7FFF_FFFF, 1'b0); send_element(-32'sh8000_0000, 1'b0);
        send_element(32'sh1, 1'b0); send_element(32'sh7FFF_FFFF, 1'b0);
        i_valid <= 1'b0;
        drain();
        // size zero acts as one, oversize acts as the maximum; restart mid-load
        write_size(4'd0);
        send_element(32'sh0002_0000, 1'b1);
        i_valid <= 1'b0;
        drain();
        write_size(4'd15);
        send_element(32'sh1234, 1'b1);
        i_valid <= 1'b0;
        write_size(4'd3);
        send_matrix(1'b1, 1'b0);
        drain();

        // random phases over several sizes, extremes among them
        random_stall = 1;
        sent = 0;
        while (sent < 300) begin
            write_size(($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 4)));
            repeat ($urandom_range(1, 3)) begin
                send_matrix($urandom_range(0, 4) != 0, $urandom_range(0, 2) != 0);
                sent += order_now() * order_now();
            end
            drain();
        end

        // long hold-off while the sender keeps offering matrices
        write_size(4'd2);
        hold_off = 1;
        fork
            begin
                repeat (1500) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (4) send_matrix(1'b1, 1'b0);
        join
        drain();

        $display("covered %0d matrices, %0d result transfers, %0d singular runs",
                 matrices_sent, results_seen, singular_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
